FILE: sv/rlh_pkg.sv
// Package for the resume latency histogram core.
// Holds the item types, operation codes and fixed widths shared by all modules.
// Depends on nothing.
package rlh_pkg;

  // Fixed field widths.
  localparam int TS_W    = 40;
  localparam int BKT_W   = 6;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;

  // Histogram geometry.
  localparam int NUM_BUCKETS = 33;
  localparam logic [BKT_W-1:0] LAST_BUCKET = 6'd32;

  // Operation codes.
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Input item.
  typedef struct packed {
    logic [1:0]       op;
    logic [TS_W-1:0]  timestamp_ms;
    logic [BKT_W-1:0] bucket_index;
  } evt_t;

  // Result item.
  typedef struct packed {
    logic             recorded;
    logic [TS_W-1:0]  latency_ms;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] bucket_count;
    logic [SUM_W-1:0] latency_sum_ms;
    logic [TS_W-1:0]  latency_max_ms;
  } res_t;

  // Item as it travels between the internal pipeline stages.
  typedef struct packed {
    logic [1:0]       op;
    logic             recorded;
    logic [TS_W-1:0]  lat;
    logic [BKT_W-1:0] bucket;
  } stage_t;

endpackage

FILE: sv/rlh_timing.sv
// Input register and event timing stage of the resume latency histogram.
// Tracks start and end times and measures the latency of end events.
// Depends on rlh_pkg.
module rlh_timing (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rlh_pkg::evt_t   in_item,
  output logic            ev_valid,
  input  logic            ev_stall,
  output rlh_pkg::stage_t ev
);

  logic                     v0;
  rlh_pkg::evt_t            item0;
  logic [rlh_pkg::TS_W-1:0] start_time;
  logic [rlh_pkg::TS_W-1:0] end_time;
  logic [rlh_pkg::TS_W-1:0] start_time_next;
  logic [rlh_pkg::TS_W-1:0] end_time_next;
  logic [rlh_pkg::TS_W-1:0] diff;
  logic                     move;

  // The input register holds while the next stage stalls.
  assign in_stall = v0 && ev_stall;
  assign move     = v0 && !ev_stall;
  assign ev_valid = v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (!in_stall) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item0 <= in_item;
    end
  end

  // Timing state changes once, when the item leaves this stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      end_time   <= '0;
    end else if (move) begin
      start_time <= start_time_next;
      end_time   <= end_time_next;
    end
  end

  assign diff = item0.timestamp_ms - start_time;

  // Decode the event and measure the latency.
  always_comb begin
    start_time_next = start_time;
    end_time_next   = end_time;
    ev.op           = item0.op;
    ev.recorded     = 1'b0;
    ev.lat          = '0;
    ev.bucket       = item0.bucket_index;
    unique case (item0.op)
      rlh_pkg::OP_BEGIN: begin
        start_time_next = item0.timestamp_ms;
      end
      rlh_pkg::OP_END: begin
        // A stored start equal to the last end marks a partial resume.
        if (start_time != end_time) begin
          end_time_next = item0.timestamp_ms;
          if (item0.timestamp_ms > start_time) begin
            ev.recorded     = 1'b1;
            ev.lat          = diff;
            start_time_next = item0.timestamp_ms;
          end
        end
      end
      rlh_pkg::OP_CLEAR, rlh_pkg::OP_READ: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/rlh_bucket.sv
// Bucket index stage of the resume latency histogram.
// Maps a latency onto its piecewise linear bucket with a reciprocal multiply.
// Depends on rlh_pkg.
module rlh_bucket #(
  parameter int STEP_SMALL  = 10,
  parameter int BOUND_SMALL = 250,
  parameter int STEP_MID    = 50,
  parameter int BOUND_MID   = 500,
  parameter int STEP_LARGE  = 250,
  parameter int BOUND_MAX   = 1000
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rlh_pkg::stage_t in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output rlh_pkg::stage_t out_item
);

  // Largest bound sets the width of a region offset.
  localparam int TOP_A = (BOUND_SMALL > BOUND_MID) ? BOUND_SMALL : BOUND_MID;
  localparam int TOP_B = (TOP_A > BOUND_MAX) ? TOP_A : BOUND_MAX;
  localparam int W     = $clog2(TOP_B);
  localparam int MW    = W + 2;
  localparam int PW    = W + MW;
  localparam int IW    = (W + 2 > 7) ? W + 2 : 7;

  // Bucket counts of the three regions.
  localparam int N_SMALL = BOUND_SMALL / STEP_SMALL;
  localparam int N_MID   = (BOUND_MID > BOUND_SMALL) ? (BOUND_MID - BOUND_SMALL) / STEP_MID : 0;
  localparam int N_LARGE = (BOUND_MAX > BOUND_MID) ? (BOUND_MAX - BOUND_MID) / STEP_LARGE : 0;

  // Reciprocals: floor(x * M >> K) equals floor(x / step) for every x below 2**W.
  localparam int K_SMALL = W + $clog2(STEP_SMALL);
  localparam int K_MID   = W + $clog2(STEP_MID);
  localparam int K_LARGE = W + $clog2(STEP_LARGE);
  localparam logic [63:0] M_SMALL_F =
    ((64'd1 << K_SMALL) + 64'(STEP_SMALL) - 64'd1) / 64'(STEP_SMALL);
  localparam logic [63:0] M_MID_F =
    ((64'd1 << K_MID) + 64'(STEP_MID) - 64'd1) / 64'(STEP_MID);
  localparam logic [63:0] M_LARGE_F =
    ((64'd1 << K_LARGE) + 64'(STEP_LARGE) - 64'd1) / 64'(STEP_LARGE);
  localparam logic [MW-1:0] M_SMALL = M_SMALL_F[MW-1:0];
  localparam logic [MW-1:0] M_MID   = M_MID_F[MW-1:0];
  localparam logic [MW-1:0] M_LARGE = M_LARGE_F[MW-1:0];

  // Region codes.
  localparam logic [1:0] RG_SMALL = 2'd0;
  localparam logic [1:0] RG_MID   = 2'd1;
  localparam logic [1:0] RG_LARGE = 2'd2;
  localparam logic [1:0] RG_OVER  = 2'd3;

  logic            v1;
  rlh_pkg::stage_t item1;
  logic [1:0]      region;
  logic [W-1:0]    x;
  logic [MW-1:0]   m;
  logic [PW-1:0]   prod;
  logic [W-1:0]    q;
  logic [IW-1:0]   idx_sum;
  logic [rlh_pkg::BKT_W-1:0] idx;
  logic [rlh_pkg::BKT_W-1:0] sel;

  assign in_stall  = v1 && out_stall;
  assign out_valid = v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!in_stall) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item1 <= in_item;
    end
  end

  // Pick the region and the offset into it.
  always_comb begin
    if (item1.lat < rlh_pkg::TS_W'(BOUND_SMALL)) begin
      region = RG_SMALL;
      x      = item1.lat[W-1:0];
      m      = M_SMALL;
    end else if (item1.lat < rlh_pkg::TS_W'(BOUND_MID)) begin
      region = RG_MID;
      x      = item1.lat[W-1:0] - W'(BOUND_SMALL);
      m      = M_MID;
    end else if (item1.lat < rlh_pkg::TS_W'(BOUND_MAX)) begin
      region = RG_LARGE;
      x      = item1.lat[W-1:0] - W'(BOUND_MID);
      m      = M_LARGE;
    end else begin
      region = RG_OVER;
      x      = '0;
      m      = '0;
    end
  end

  assign prod = PW'(x) * PW'(m);

  // Quotient within the region plus the buckets of the regions below it.
  always_comb begin
    case (region)
      RG_SMALL: begin
        q       = W'(prod >> K_SMALL);
        idx_sum = IW'(q);
      end
      RG_MID: begin
        q       = W'(prod >> K_MID);
        idx_sum = IW'(q) + IW'(N_SMALL);
      end
      RG_LARGE: begin
        q       = W'(prod >> K_LARGE);
        idx_sum = IW'(q) + IW'(N_SMALL) + IW'(N_MID);
      end
      default: begin
        q       = '0;
        idx_sum = IW'(N_SMALL) + IW'(N_MID) + IW'(N_LARGE);
      end
    endcase
  end

  // Indexes beyond the array land in the overflow bucket.
  assign idx = (idx_sum > IW'(rlh_pkg::LAST_BUCKET)) ? rlh_pkg::LAST_BUCKET
                                                      : idx_sum[rlh_pkg::BKT_W-1:0];
  assign sel = (item1.bucket > rlh_pkg::LAST_BUCKET) ? rlh_pkg::LAST_BUCKET : item1.bucket;

  // Bucket for the histogram stage: counted bucket, read bucket, or zero.
  always_comb begin
    out_item = item1;
    if (item1.op == rlh_pkg::OP_READ) begin
      out_item.bucket = sel;
    end else if (item1.recorded) begin
      out_item.bucket = idx;
    end else begin
      out_item.bucket = '0;
    end
  end

endmodule

FILE: sv/rlh_hist.sv
// Histogram stage of the resume latency histogram.
// Holds the bucket counter memory, the latency sum and maximum, and the result register.
// Depends on rlh_pkg.
module rlh_hist (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  rlh_pkg::stage_t in_item,
  output logic            res_valid,
  input  logic            res_stall,
  output rlh_pkg::res_t   res
);

  localparam logic [rlh_pkg::CNT_W-1:0] CNT_MAX = '1;
  localparam logic [rlh_pkg::SUM_W-1:0] SUM_MAX = '1;

  logic                          v2;
  rlh_pkg::stage_t               item2;
  logic [rlh_pkg::CNT_W-1:0]     mem [rlh_pkg::NUM_BUCKETS];
  logic [rlh_pkg::NUM_BUCKETS-1:0] vbit;
  logic [rlh_pkg::CNT_W-1:0]     rd_mem;
  logic                          rd_vbit;
  logic                          fwd_hit;
  logic                          fwd_clr;
  logic [rlh_pkg::CNT_W-1:0]     fwd_val;
  logic [rlh_pkg::CNT_W-1:0]     base;
  logic [rlh_pkg::CNT_W-1:0]     cnt_inc;
  logic [rlh_pkg::SUM_W-1:0]     sum_total;
  logic [rlh_pkg::SUM_W-1:0]     sum_total_next;
  logic [rlh_pkg::TS_W-1:0]      max_seen;
  logic [rlh_pkg::TS_W-1:0]      max_seen_next;
  logic [rlh_pkg::SUM_W:0]       sum_add;
  logic                          move2;
  logic                          wr;
  logic                          clr;
  rlh_pkg::res_t                 res_d;

  // The stage moves when the result register is free or being emptied.
  assign move2    = v2 && (!res_valid || !res_stall);
  assign in_stall = v2 && !move2;
  assign wr       = move2 && (item2.op == rlh_pkg::OP_END) && item2.recorded;
  assign clr      = move2 && (item2.op == rlh_pkg::OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (!in_stall) begin
      v2 <= in_valid;
    end
  end

  // Counter memory: one write and one registered read per cycle; the read holds while the stage stalls.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[item2.bucket] <= cnt_inc;
    end
    if (!in_stall) begin
      rd_mem <= mem[in_item.bucket];
    end
  end

  // The incoming item sees this cycle's write or clear through the bypass flags.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item2   <= in_item;
      rd_vbit <= vbit[in_item.bucket];
      fwd_hit <= wr && (item2.bucket == in_item.bucket);
      fwd_clr <= clr;
      fwd_val <= cnt_inc;
    end
  end

  // Entry valid bits stand for the all-zero state after reset or clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit <= '0;
    end else if (clr) begin
      vbit <= '0;
    end else if (wr) begin
      vbit[item2.bucket] <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_clr) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_val;
    end else if (rd_vbit) begin
      base = rd_mem;
    end else begin
      base = '0;
    end
  end

  // Saturating counter increment and sum.
  assign cnt_inc = (base == CNT_MAX) ? base : base + 1'b1;
  assign sum_add = {1'b0, sum_total} + (rlh_pkg::SUM_W + 1)'(item2.lat);

  always_comb begin
    sum_total_next = sum_total;
    max_seen_next  = max_seen;
    if (item2.op == rlh_pkg::OP_CLEAR) begin
      sum_total_next = '0;
      max_seen_next  = '0;
    end else if ((item2.op == rlh_pkg::OP_END) && item2.recorded) begin
      sum_total_next = sum_add[rlh_pkg::SUM_W] ? SUM_MAX : sum_add[rlh_pkg::SUM_W-1:0];
      if (item2.lat > max_seen) begin
        max_seen_next = item2.lat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_total <= '0;
      max_seen  <= '0;
    end else if (move2) begin
      sum_total <= sum_total_next;
      max_seen  <= max_seen_next;
    end
  end

  // Build the result item.
  always_comb begin
    res_d.recorded       = 1'b0;
    res_d.latency_ms     = '0;
    res_d.bucket         = '0;
    res_d.bucket_count   = '0;
    res_d.latency_sum_ms = sum_total_next;
    res_d.latency_max_ms = max_seen_next;
    if ((item2.op == rlh_pkg::OP_END) && item2.recorded) begin
      res_d.recorded     = 1'b1;
      res_d.latency_ms   = item2.lat;
      res_d.bucket       = item2.bucket;
      res_d.bucket_count = cnt_inc;
    end else if (item2.op == rlh_pkg::OP_READ) begin
      res_d.bucket       = item2.bucket;
      res_d.bucket_count = base;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res <= res_d;
    end
  end

endmodule

FILE: sv/resume_latency_histogram_core.sv
// Top level of the resume latency histogram core.
// Chains the timing, bucket index and histogram stages; depends on rlh_pkg,
// rlh_timing, rlh_bucket and rlh_hist.
//
//   channel  valid      stall      payload
//   -------  ---------  ---------  ----------------------
//   input    evt_valid  evt_stall  evt (rlh_pkg::evt_t)
//   result   res_valid  res_stall  res (rlh_pkg::res_t)
//
// Every item yields one result item. The core takes one item per cycle while
// no stall holds it; a result passes from the input register through the
// bucket index register and the counter read register into the result register.
// Reset is synchronous and clears all timing state, the sum, the maximum and
// the counter valid bits at once. A stall on the result side holds each stage
// in turn; the input keeps flowing until every stage is full.
module resume_latency_histogram_core #(
  parameter int STEP_SMALL  = 10,
  parameter int BOUND_SMALL = 250,
  parameter int STEP_MID    = 50,
  parameter int BOUND_MID   = 500,
  parameter int STEP_LARGE  = 250,
  parameter int BOUND_MAX   = 1000
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          evt_valid,
  output logic          evt_stall,
  input  rlh_pkg::evt_t evt,
  output logic          res_valid,
  input  logic          res_stall,
  output rlh_pkg::res_t res
);

  logic            ev_valid;
  logic            ev_stall;
  rlh_pkg::stage_t ev;
  logic            bk_valid;
  logic            bk_stall;
  rlh_pkg::stage_t bk;

  // Start and end times, latency measurement.
  rlh_timing u_timing (
    .clk      (clk),
    .rst      (rst),
    .in_valid (evt_valid),
    .in_stall (evt_stall),
    .in_item  (evt),
    .ev_valid (ev_valid),
    .ev_stall (ev_stall),
    .ev       (ev)
  );

  // Piecewise linear bucket index.
  rlh_bucket #(
    .STEP_SMALL  (STEP_SMALL),
    .BOUND_SMALL (BOUND_SMALL),
    .STEP_MID    (STEP_MID),
    .BOUND_MID   (BOUND_MID),
    .STEP_LARGE  (STEP_LARGE),
    .BOUND_MAX   (BOUND_MAX)
  ) u_bucket (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ev_valid),
    .in_stall  (ev_stall),
    .in_item   (ev),
    .out_valid (bk_valid),
    .out_stall (bk_stall),
    .out_item  (bk)
  );

  // Counters, sum, maximum and result register.
  rlh_hist u_hist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bk_valid),
    .in_stall  (bk_stall),
    .in_item   (bk),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
